FILE: rtl/harris_corner_mark_3x3_assert.svh
// assertion macros used by hcm_back
`ifndef HARRIS_CORNER_MARK_3X3_ASSERT_SVH
`define HARRIS_CORNER_MARK_3X3_ASSERT_SVH

// same-cycle implication
`define HCM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcm assertion failed");

// next-cycle implication
`define HCM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcm assertion failed");

`endif

FILE: rtl/hcm_pkg.sv
// ---------------------------------------------------------------------------
// hcm_pkg
// types and constants shared by the harris corner marker
// ---------------------------------------------------------------------------
package hcm_pkg;

  localparam int VALUE_BITS = 32;
  localparam int QUO_BITS   = 33;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_THRESHOLD = 2'd2;

  localparam logic [11:0]        WIDTH_RESET     = 12'd640;
  localparam logic [12:0]        HEIGHT_RESET    = 13'd480;
  localparam logic signed [31:0] THRESHOLD_RESET = 32'sd2560;

  localparam logic [QUO_BITS-1:0] QUO_MAXPOS = 33'h0_7FFF_FFFF;
  localparam logic [QUO_BITS-1:0] QUO_MINMAG = 33'h0_8000_0000;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [63:0]                  prod_t;
  typedef logic [QUO_BITS-1:0]          trace_t;

  typedef struct packed {
    logic [31:0]        grad_xx;
    logic [31:0]        grad_yy;
    logic signed [31:0] grad_xy;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic               center_valid;
    logic               is_corner;
    logic signed [31:0] center_response;
    logic               frame_end;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        grad_xx;
    logic [31:0]        grad_yy;
    logic signed [31:0] grad_xy;
  } grad_t;

  // per-pixel classification from the front end
  typedef struct packed {
    logic center_valid;
    logic frame_end;
  } tag_t;

endpackage

FILE: rtl/hcm_front.sv
// ---------------------------------------------------------------------------
// hcm_front
// accepts pixels, tracks raster position and tags each word
// ---------------------------------------------------------------------------
module hcm_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_BITS  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  hcm_pkg::in_item_t     pixel,
  input  logic [11:0]           image_width,
  input  logic [12:0]           image_height,
  output logic                  q_wr,
  output hcm_pkg::grad_t        q_grad,
  output logic [COL_BITS-1:0]   q_col,
  output hcm_pkg::tag_t         q_tag
);

  localparam int CW = ((COL_BITS > 12) ? COL_BITS : 12) + 1;
  localparam int RW = 14;

  logic [COL_BITS-1:0] col_cnt;
  logic [12:0]         row_cnt;

  logic [CW-1:0] weff;
  logic [RW-1:0] heff;
  logic [CW-1:0] c0, c1;
  logic [RW-1:0] r0, r1;

  always_comb begin
    if (image_width == 12'd0) begin
      weff = CW'(1);
    end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
      weff = CW'(MAX_WIDTH);
    end else begin
      weff = CW'(image_width);
    end
    heff = (image_height == 13'd0) ? RW'(1) : RW'(image_height);

    c0 = pixel.frame_start ? '0 : CW'(col_cnt);
    r0 = pixel.frame_start ? '0 : RW'(row_cnt);
    // shrunk width: wrap to next row
    if (c0 >= weff) begin
      c0 = '0;
      r0 = r0 + RW'(1);
    end
    if (r0 >= heff) begin
      r0 = '0;
    end

    c1 = c0 + CW'(1);
    r1 = r0;
    if (c1 >= weff) begin
      c1 = '0;
      r1 = r0 + RW'(1);
      if (r1 >= heff) begin
        r1 = '0;
      end
    end
  end

  assign q_wr   = push && !full;
  assign q_grad = '{grad_xx: pixel.grad_xx, grad_yy: pixel.grad_yy, grad_xy: pixel.grad_xy};
  assign q_col  = c0[COL_BITS-1:0];
  assign q_tag.center_valid = (r0 >= RW'(2)) && (c0 >= CW'(2));
  assign q_tag.frame_end    = (c0 == weff - CW'(1)) && (r0 == heff - RW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (q_wr) begin
      col_cnt <= c1[COL_BITS-1:0];
      row_cnt <= r1[12:0];
    end
  end

endmodule

FILE: rtl/hcm_queue.sv
// ---------------------------------------------------------------------------
// hcm_queue
// small register queue between front end and response pipeline
// ---------------------------------------------------------------------------
module hcm_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [DW-1:0] wdata,
  input  logic          rd,
  output logic [DW-1:0] rdata,
  output logic          q_full,
  output logic          q_empty
);

  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] slots [0:DEPTH-1];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign q_full  = (count == (PW+1)'(DEPTH));
  assign q_empty = (count == '0);
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= wp + PW'(1);
      end
      if (rd) begin
        rp <= rp + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + (PW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/hcm_resp.sv
// ---------------------------------------------------------------------------
// hcm_resp
// response pipeline: determinant, trace and a one-bit-per-stage divider
// ---------------------------------------------------------------------------
module hcm_resp #(
  parameter int COL_BITS = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  hcm_pkg::grad_t      in_grad,
  input  logic [COL_BITS-1:0] in_col,
  input  hcm_pkg::tag_t       in_tag,
  output logic                out_valid,
  output hcm_pkg::value_t     out_resp,
  output logic [COL_BITS-1:0] out_col,
  output hcm_pkg::tag_t       out_tag
);

  localparam int NQ = hcm_pkg::QUO_BITS;

  // magnitude of xy, so its square is a 32 by 32 unsigned product
  logic [31:0]           xy_abs;

  // products and trace
  logic                  s1_v;
  hcm_pkg::prod_t        s1_p, s1_q;
  hcm_pkg::trace_t       s1_tr;
  logic [COL_BITS-1:0]   s1_col;
  hcm_pkg::tag_t         s1_tag;

  // determinant magnitude and sign
  logic                  s2_v;
  hcm_pkg::prod_t        s2_mag;
  logic                  s2_neg;
  hcm_pkg::trace_t       s2_tr;
  logic [COL_BITS-1:0]   s2_col;
  hcm_pkg::tag_t         s2_tag;

  logic [64:0]           d_pq;
  hcm_pkg::prod_t        mag_next;

  // divider stages
  logic                  dv_v    [0:NQ];
  hcm_pkg::trace_t       dv_rem  [0:NQ];
  hcm_pkg::trace_t       dv_low  [0:NQ];
  hcm_pkg::trace_t       dv_quo  [0:NQ];
  hcm_pkg::trace_t       dv_tr   [0:NQ];
  logic                  dv_neg  [0:NQ];
  logic                  dv_ovf  [0:NQ];
  logic                  dv_zero [0:NQ];
  logic [COL_BITS-1:0]   dv_col  [0:NQ];
  hcm_pkg::tag_t         dv_tag  [0:NQ];

  hcm_pkg::trace_t       nx_rem  [0:NQ-1];
  logic                  nx_bit  [0:NQ-1];

  hcm_pkg::trace_t       fin_q;
  hcm_pkg::trace_t       fin_negq;
  hcm_pkg::value_t       fin_val;

  assign xy_abs = in_grad.grad_xy[31] ? 32'(-in_grad.grad_xy) : in_grad.grad_xy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p   <= 64'(in_grad.grad_xx) * 64'(in_grad.grad_yy);
      s1_q   <= 64'(xy_abs) * 64'(xy_abs);
      s1_tr  <= hcm_pkg::QUO_BITS'(in_grad.grad_xx) + hcm_pkg::QUO_BITS'(in_grad.grad_yy);
      s1_col <= in_col;
      s1_tag <= in_tag;
    end
  end

  assign d_pq     = {1'b0, s1_p} - {1'b0, s1_q};
  assign mag_next = d_pq[64] ? (s1_q - s1_p) : d_pq[63:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag <= mag_next;
      s2_neg <= d_pq[64];
      s2_tr  <= s1_tr;
      s2_col <= s1_col;
      s2_tag <= s1_tag;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NQ:0] sh;
    for (int i = 0; i < NQ; i++) begin
      sh        = {dv_rem[i], dv_low[i][NQ-1]};
      nx_bit[i] = (sh >= {1'b0, dv_tr[i]});
      nx_rem[i] = nx_bit[i] ? NQ'(sh - {1'b0, dv_tr[i]}) : sh[NQ-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // quotient of 2^33 or more is saturated anyway
      dv_rem[0]  <= NQ'(s2_mag[63:NQ]);
      dv_low[0]  <= s2_mag[NQ-1:0];
      dv_quo[0]  <= '0;
      dv_tr[0]   <= s2_tr;
      dv_neg[0]  <= s2_neg;
      dv_ovf[0]  <= (NQ'(s2_mag[63:NQ]) >= s2_tr);
      dv_zero[0] <= (s2_tr == '0);
      dv_col[0]  <= s2_col;
      dv_tag[0]  <= s2_tag;
      for (int i = 0; i < NQ; i++) begin
        dv_rem[i+1]  <= nx_rem[i];
        dv_low[i+1]  <= {dv_low[i][NQ-2:0], 1'b0};
        dv_quo[i+1]  <= {dv_quo[i][NQ-2:0], nx_bit[i]};
        dv_tr[i+1]   <= dv_tr[i];
        dv_neg[i+1]  <= dv_neg[i];
        dv_ovf[i+1]  <= dv_ovf[i];
        dv_zero[i+1] <= dv_zero[i];
        dv_col[i+1]  <= dv_col[i];
        dv_tag[i+1]  <= dv_tag[i];
      end
    end
  end

  assign fin_q    = dv_quo[NQ];
  assign fin_negq = NQ'(0) - fin_q;

  always_comb begin
    if (dv_zero[NQ]) begin
      fin_val = '0;
    end else if (!dv_neg[NQ]) begin
      fin_val = (dv_ovf[NQ] || fin_q > hcm_pkg::QUO_MAXPOS) ?
                hcm_pkg::QUO_MAXPOS[31:0] : fin_q[31:0];
    end else begin
      fin_val = (dv_ovf[NQ] || fin_q > hcm_pkg::QUO_MINMAG) ?
                hcm_pkg::QUO_MINMAG[31:0] : fin_negq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_resp <= fin_val;
      out_col  <= dv_col[NQ];
      out_tag  <= dv_tag[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= NQ; i++) begin
        dv_v[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_v    <= in_valid;
      s2_v    <= s1_v;
      dv_v[0] <= s2_v;
      for (int i = 0; i < NQ; i++) begin
        dv_v[i+1] <= dv_v[i];
      end
      out_valid <= dv_v[NQ];
    end
  end

endmodule

FILE: rtl/hcm_back.sv
// ---------------------------------------------------------------------------
// hcm_back
// line buffers, 3x3 window, local maximum test and result register
// ---------------------------------------------------------------------------
`include "harris_corner_mark_3x3_assert.svh"

module hcm_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_BITS  = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  hcm_pkg::value_t     threshold,
  input  logic                in_valid,
  input  hcm_pkg::value_t     in_resp,
  input  logic [COL_BITS-1:0] in_col,
  input  hcm_pkg::tag_t       in_tag,
  input  logic                pop,
  output logic                empty,
  output hcm_pkg::out_item_t  mark,
  output logic                adv,
  output logic                clearing
);

  localparam logic [COL_BITS-1:0] CLR_LAST = COL_BITS'(MAX_WIDTH - 1);

  // each entry holds {older row, newer row}
  logic [63:0]           lbuf [0:MAX_WIDTH-1];
  logic [63:0]           mem_rd;
  logic                  mem_we;
  logic [COL_BITS-1:0]   mem_wa;
  logic [63:0]           mem_wd;
  logic [COL_BITS-1:0]   clr_addr;

  logic                  fwd;
  logic [63:0]           fwd_data;
  logic [63:0]           ent;
  logic [63:0]           ent_new;

  logic                  b_valid;
  hcm_pkg::value_t       b_resp;
  logic [COL_BITS-1:0]   b_col;
  hcm_pkg::tag_t         b_tag;

  hcm_pkg::value_t       win [0:2][0:2];
  hcm_pkg::value_t       newcol [0:2];
  hcm_pkg::value_t       center;
  logic                  beaten;
  logic                  corner;
  logic                  out_valid;

  assign empty = !out_valid;
  assign adv   = !out_valid || pop;

  assign ent     = fwd ? fwd_data : mem_rd;
  assign ent_new = {ent[31:0], b_resp};

  assign mem_we = clearing || (adv && b_valid);
  assign mem_wa = clearing ? clr_addr : b_col;
  assign mem_wd = clearing ? '0 : ent_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lbuf[mem_wa] <= mem_wd;
    end
    if (adv) begin
      mem_rd <= lbuf[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_BITS'(1);
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // same column written back while being read: bypass the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (adv) begin
      fwd <= b_valid && in_valid && (b_col == in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= ent_new;
      b_resp   <= in_resp;
      b_col    <= in_col;
      b_tag    <= in_tag;
    end
  end

  assign newcol[0] = ent[63:32];
  assign newcol[1] = ent[31:0];
  assign newcol[2] = b_resp;
  assign center    = win[1][2];

  always_comb begin
    beaten = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (win[i][1] > center || win[i][2] > center || newcol[i] > center) begin
        beaten = 1'b1;
      end
    end
    corner = b_tag.center_valid && (center > threshold) && !beaten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (adv && b_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
        win[i][2] <= newcol[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mark.center_valid    <= b_tag.center_valid;
      mark.is_corner       <= corner;
      mark.center_response <= b_tag.center_valid ? center : '0;
      mark.frame_end       <= b_tag.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b_valid   <= in_valid;
      out_valid <= b_valid;
    end
  end

  `HCM_ASSERT_IMP(a_idle_while_clearing, clk, rst, clearing, !b_valid && !in_valid)
  `HCM_ASSERT_IMP(a_corner_is_interior, clk, rst, out_valid && mark.is_corner, mark.center_valid)
  `HCM_ASSERT_IMP(a_bypass_has_word, clk, rst, fwd, b_valid)
  `HCM_ASSERT_NXT(a_clear_ends, clk, rst, clearing && clr_addr == CLR_LAST, !clearing)

endmodule

FILE: rtl/harris_corner_mark_3x3.sv
// ---------------------------------------------------------------------------
// harris_corner_mark_3x3
// harris corner response with 3x3 local maximum marking, raster stream
// ---------------------------------------------------------------------------
//  channel   ports                       word
//  pixel     push, full, pixel           grad_xx, grad_yy, grad_xy, frame_start
//  mark      empty, pop, mark            center_valid, is_corner, center_response,
//                                        frame_end
//  config    cfg_wen, cfg_index, cfg_data  width, height, threshold
//
// one pixel per cycle sustained while pop keeps up; each mark leaves after its pixel
// has passed products, determinant, 33 divider stages, saturation, line buffer read, window
// after reset the line buffers are zeroed with full high
// a stall on pop halts the whole response pipeline; the 4-word queue behind the
// front end absorbs pixels until it fills
module harris_corner_mark_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  hcm_pkg::in_item_t                   pixel,
  output logic                                empty,
  input  logic                                pop,
  output hcm_pkg::out_item_t                  mark,
  input  logic                                cfg_wen,
  input  logic [hcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hcm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int QDW = $bits(hcm_pkg::grad_t) + $bits(hcm_pkg::tag_t) + COL_BITS;

  logic [11:0]      image_width;
  logic [12:0]      image_height;
  hcm_pkg::value_t  corner_threshold;

  logic                q_wr, q_full, q_empty, q_rd;
  hcm_pkg::grad_t      f_grad, r_grad;
  logic [COL_BITS-1:0] f_col, r_col, p_col;
  hcm_pkg::tag_t       f_tag, r_tag, p_tag;
  logic [QDW-1:0]      q_rdata;

  logic                p_valid;
  hcm_pkg::value_t     p_resp;
  logic                adv, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= hcm_pkg::WIDTH_RESET;
      image_height     <= hcm_pkg::HEIGHT_RESET;
      corner_threshold <= hcm_pkg::THRESHOLD_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        hcm_pkg::REG_IMAGE_WIDTH:      image_width      <= cfg_data[11:0];
        hcm_pkg::REG_IMAGE_HEIGHT:     image_height     <= cfg_data[12:0];
        hcm_pkg::REG_CORNER_THRESHOLD: corner_threshold <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign full = q_full || clearing;

  hcm_front #(.MAX_WIDTH(MAX_WIDTH), .COL_BITS(COL_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .q_wr         (q_wr),
    .q_grad       (f_grad),
    .q_col        (f_col),
    .q_tag        (f_tag)
  );

  assign q_rd = adv && !q_empty;

  hcm_queue #(.DW(QDW), .DEPTH(4)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   ({f_col, f_tag, f_grad}),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  assign {r_col, r_tag, r_grad} = q_rdata;

  hcm_resp #(.COL_BITS(COL_BITS)) u_resp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (!q_empty),
    .in_grad   (r_grad),
    .in_col    (r_col),
    .in_tag    (r_tag),
    .out_valid (p_valid),
    .out_resp  (p_resp),
    .out_col   (p_col),
    .out_tag   (p_tag)
  );

  hcm_back #(.MAX_WIDTH(MAX_WIDTH), .COL_BITS(COL_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (corner_threshold),
    .in_valid  (p_valid),
    .in_resp   (p_resp),
    .in_col    (p_col),
    .in_tag    (p_tag),
    .pop       (pop),
    .empty     (empty),
    .mark      (mark),
    .adv       (adv),
    .clearing  (clearing)
  );

endmodule

FILE: sim/tb_harris_corner_mark_3x3.sv
// ---------------------------------------------------------------------------
// tb_harris_corner_mark_3x3
// self-checking bench for the harris corner marker
// ---------------------------------------------------------------------------
// Pixel frames go through a series of frame sizes and thresholds. The sizes
// include the smallest, the clamped and zero ones, and some that shrink in the
// middle of a frame. Each accepted pixel runs through a local model of the
// response, the line buffers and the 3x3 maximum test. Every mark that comes
// out is checked field by field against the oldest predicted mark. The sender
// pushes in bursts and the receiver stalls on a changing pattern.
// ---------------------------------------------------------------------------
module tb_harris_corner_mark_3x3;

  localparam int LB_DEPTH  = 2048;
  localparam int WD_LIMIT  = 20000;
  localparam int TAIL_WAIT = 60;

  // index that no register answers to
  localparam logic [hcm_pkg::CFG_INDEX_BITS-1:0] REG_UNKNOWN = 2'd3;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  hcm_pkg::in_item_t  pixel;
  logic               empty;
  logic               pop;
  hcm_pkg::out_item_t mark;
  logic               cfg_wen;
  logic [hcm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [hcm_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  harris_corner_mark_3x3 i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .mark(mark),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // model state
  logic [11:0]        mdl_width  = hcm_pkg::WIDTH_RESET;
  logic [12:0]        mdl_height = hcm_pkg::HEIGHT_RESET;
  logic signed [31:0] mdl_thresh = hcm_pkg::THRESHOLD_RESET;
  logic signed [31:0] line_prev [LB_DEPTH];
  logic signed [31:0] line_last [LB_DEPTH];
  logic signed [31:0] win [3][3];
  int col_cnt, row_cnt;

  hcm_pkg::in_item_t  pixel_q[$];
  hcm_pkg::out_item_t mark_q[$];

  int errors, pixels_in, marks_out, corners_seen, interior_seen, phases;
  int idle_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at mark %0d: %s got %0h expected %0h", marks_out, what, got, want);
    errors++;
  endtask

  function automatic logic signed [31:0] harris_value(logic [31:0] xx, logic [31:0] yy,
                                                    logic signed [31:0] xy);
    logic [63:0] p, q, mag, quo;
    logic [31:0] axy;
    logic [32:0] tr;
    p   = 64'(xx) * 64'(yy);
    axy = xy[31] ? 32'(-33'(xy)) : xy;
    q   = 64'(axy) * 64'(axy);
    tr  = {1'b0, xx} + {1'b0, yy};
    if (tr == 0) return 32'sd0;
    if (p >= q) begin
      quo = (p - q) / 64'(tr);
      return (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
    mag = q - p;
    quo = mag / 64'(tr);
    if (quo > 64'h8000_0000) quo = 64'h8000_0000;
    return 32'(-quo);
  endfunction

  task automatic predict_mark(input hcm_pkg::in_item_t px, output hcm_pkg::out_item_t m);
    int w, h, col, row;
    logic signed [31:0] r, c;
    bit valid, corner, last;
    w = mdl_width;
    if (w == 0) w = 1;
    if (w > LB_DEPTH) w = LB_DEPTH;
    h = mdl_height;
    if (h == 0) h = 1;
    if (px.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    // counters past a shrunken size wrap
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    r = harris_value(px.grad_xx, px.grad_yy, px.grad_xy);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_last[col];
    win[1][2] = line_prev[col];
    win[2][2] = r;
    line_last[col] = line_prev[col];
    line_prev[col] = r;
    valid  = (row >= 2) && (col >= 2);
    c      = win[1][1];
    corner = 1'b0;
    if (valid && c > mdl_thresh) begin
      corner = 1'b1;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (win[i][j] > c) corner = 1'b0;
    end
    last = (col == w - 1) && (row == h - 1);
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    m.center_valid    = valid;
    m.is_corner       = corner;
    m.center_response = valid ? c : 32'sd0;
    m.frame_end       = last;
  endtask

  // sender: bursts of random length with gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    hcm_pkg::out_item_t m;
    logic               nxt_push;
    hcm_pkg::in_item_t  nxt_pixel;
    nxt_push  = push;
    nxt_pixel = pixel;
    if (rst) begin
      nxt_push = 1'b0;
    end else begin
      if (push && !full) begin
        predict_mark(pixel, m);
        mark_q.insert(mark_q.size(), m);
        pixels_in++;
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() > 0) begin
          nxt_push  = 1'b1;
          nxt_pixel = pixel_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    push  <= nxt_push;
    pixel <= nxt_pixel;
  end

  // receiver: pops follow a 16-bit stall pattern that is redrawn at random
  logic [15:0] pop_pattern = 16'hFFFF;
  int          pop_phase;
  always @(posedge clk) begin
    pop_phase++;
    if (pop_phase % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: pop_pattern = 16'hFFFF;
        1: pop_pattern = 16'h00FF;
        default: pop_pattern = $urandom;
      endcase
    end
    pop <= pop_pattern[pop_phase % 16];
  end

  // result checker
  always @(posedge clk) begin
    hcm_pkg::out_item_t want;
    if (!rst && pop && !empty) begin
      marks_out++;
      if (mark_q.size() == 0) begin
        report_mismatch("unexpected mark word", mark, 0);
      end else begin
        want = mark_q.pop_front();
        if (mark.center_valid !== want.center_valid)
          report_mismatch("center_valid", mark.center_valid, want.center_valid);
        if (mark.is_corner !== want.is_corner)
          report_mismatch("is_corner", mark.is_corner, want.is_corner);
        if (mark.center_response !== want.center_response)
          report_mismatch("center_response", mark.center_response, want.center_response);
        if (mark.frame_end !== want.frame_end)
          report_mismatch("frame_end", mark.frame_end, want.frame_end);
        if (want.center_valid) interior_seen++;
        if (want.is_corner) corners_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [hcm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    case (idx)
      hcm_pkg::REG_IMAGE_WIDTH:      mdl_width  = data[11:0];
      hcm_pkg::REG_IMAGE_HEIGHT:     mdl_height = data[12:0];
      hcm_pkg::REG_CORNER_THRESHOLD: mdl_thresh = data;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pixel_q.size() > 0 || push || mark_q.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  function automatic hcm_pkg::in_item_t random_pixel(bit fs);
    hcm_pkg::in_item_t px;
    if ($urandom_range(0, 4) == 0) begin
      px.grad_xx = $urandom;
      px.grad_yy = $urandom;
      px.grad_xy = $urandom;
    end else begin
      px.grad_xx = $urandom_range(0, 4000);
      px.grad_yy = $urandom_range(0, 4000);
      px.grad_xy = $signed($urandom_range(0, 6000)) - 3000;
    end
    px.frame_start = fs || ($urandom_range(0, 60) == 0);
    return px;
  endfunction

  // n pixels of frames of w x h, ends mid-frame when n is not a multiple
  task automatic queue_frames(input int w, input int h, input int n);
    for (int i = 0; i < n; i++)
      pixel_q.insert(pixel_q.size(), random_pixel(i % (w * h) == 0));
  endtask

  task automatic run_phase(input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] thr, input int n);
    write_reg(hcm_pkg::REG_IMAGE_WIDTH, w);
    write_reg(hcm_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(hcm_pkg::REG_CORNER_THRESHOLD, thr);
    begin
      int ew, eh;
      ew = (w[11:0] == 0) ? 1 : (w[11:0] > LB_DEPTH ? LB_DEPTH : w[11:0]);
      eh = (h[12:0] == 0) ? 1 : h[12:0];
      queue_frames(ew, eh, n);
    end
    phases++;
    drain();
  endtask

  initial begin
    hcm_pkg::in_item_t px;
    rst       <= 1'b1;
    push      <= 1'b0;
    pixel     <= '0;
    pop       <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_last[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // a few pixels at reset defaults
    queue_frames(640, 480, 12);
    drain();

    // directed extremes in a 4x6 frame with a zero threshold
    write_reg(hcm_pkg::REG_IMAGE_WIDTH, 4);
    write_reg(hcm_pkg::REG_IMAGE_HEIGHT, 6);
    write_reg(hcm_pkg::REG_CORNER_THRESHOLD, 0);
    for (int i = 0; i < 24; i++) begin
      px = random_pixel(i == 0);
      case (i)
        0: px = '{grad_xx: 0, grad_yy: 0, grad_xy: 0, frame_start: 1'b1};
        1: px = '{grad_xx: '1, grad_yy: '1, grad_xy: 0, frame_start: 1'b0};
        2: px = '{grad_xx: 0, grad_yy: 1, grad_xy: 32'sh8000_0000, frame_start: 1'b0};
        3: px = '{grad_xx: 1, grad_yy: 0, grad_xy: 32'sh7FFF_FFFF, frame_start: 1'b0};
        5: px = '{grad_xx: '1, grad_yy: '1, grad_xy: '1, frame_start: 1'b0};
        6: px = '{grad_xx: '1, grad_yy: 0, grad_xy: 32'sh8000_0000, frame_start: 1'b0};
        9: px = '{grad_xx: 32'h0000_4000, grad_yy: 32'h0000_4000, grad_xy: 0,
                  frame_start: 1'b0};
        10: px = '{grad_xx: 32'h0000_4000, grad_yy: 32'h0000_4000, grad_xy: 0,
                   frame_start: 1'b0};
        default: ;
      endcase
      pixel_q.insert(pixel_q.size(), px);
    end
    phases++;
    drain();

    // unknown register index is ignored
    write_reg(REG_UNKNOWN, $urandom);

    run_phase(3, 3, 32'h8000_0000, 30);
    run_phase(4095, 8191, 32'h7FFF_FFFF, 40);
    run_phase(0, 0, 0, 10);
    run_phase(2, 7, 32'hFFFF_FF00, 20);
    run_phase(7, 2, 0, 20);
    run_phase(150, 4, 500, 400);
    // shrink mid-frame: counters sit past the new size
    run_phase(12, 10, 1000, 70);
    run_phase(4, 3, 1000, 14);

    while (pixels_in < 800) begin
      int w, h;
      logic [31:0] thr;
      w   = $urandom_range(3, 12);
      h   = $urandom_range(3, 10);
      thr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
      run_phase(w, h, thr, w * h * $urandom_range(1, 3) + $urandom_range(0, 5));
    end

    $display("%0d pixels over %0d settings, %0d marks checked, %0d interior, %0d corners",
             pixels_in, phases, marks_out, interior_seen, corners_seen);
    if (errors == 0) $display("RESULT: OK");
    else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
